// ===== rtl/core/kvt_pkg.sv =====
// Package for the key/value table: table sizing, index widths and action codes.
// No dependencies; used by key_value_table and kvt_checker.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

endpackage

`default_nettype wire

// ===== rtl/core/key_value_table.sv =====
// An accepted command goes through the input register and then the result register;
// its result shows for one cycle with out_valid high. Throughput: one command per cycle.
// busy is never raised; the result is pushed out and cannot be held off.
// The lookup, free-slot pick and table update run in the cycle after the input register.
// Reset (synchronous, active low) clears all valid marks and the entry count at once;
// keys and data are not cleared, an entry is read only while it is valid.
`timescale 1ns / 1ps
`default_nettype none

module key_value_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  in_action,
  input  wire logic signed [kvt_pkg::KEY_W-1:0]  in_key,
  input  wire logic signed [kvt_pkg::DATA_W-1:0] in_data_in,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [kvt_pkg::DATA_W-1:0] out_data_out,
  output logic                             out_full_res,
  output logic [kvt_pkg::COUNT_W-1:0]      out_count,
  output logic                             out_empty_res
);

  localparam int N = kvt_pkg::ENTRIES;

  // input register
  logic                        cmd_v_r;
  logic [1:0]                  cmd_act_r;
  logic [kvt_pkg::KEY_W-1:0]   cmd_key_r;
  logic [kvt_pkg::DATA_W-1:0]  cmd_din_r;

  // table
  logic [N-1:0]                valid_r, valid_nxt;
  logic [kvt_pkg::KEY_W-1:0]   key_r  [N];
  logic [kvt_pkg::DATA_W-1:0]  data_r [N];
  logic [kvt_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  // result register
  logic                        res_v_r;
  logic                        res_hit_r, res_hit_nxt;
  logic [kvt_pkg::DATA_W-1:0]  res_data_r, res_data_nxt;
  logic                        res_full_r, res_full_nxt;
  logic [kvt_pkg::COUNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic                        res_empty_r, res_empty_nxt;

  logic [N-1:0]                match;
  logic                        hit_any, free_any;
  logic [kvt_pkg::IDX_W-1:0]   hit_idx, free_idx, wr_idx;
  logic                        wr_key_en, wr_data_en;
  logic [kvt_pkg::CNT_W+kvt_pkg::COUNT_W-1:0] cnt_ext;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= start && !busy;
    end
    cmd_act_r <= in_action;
    cmd_key_r <= in_key;
    cmd_din_r <= in_data_in;
  end

  // parallel key compare and lowest-index picks
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (key_r[i] == cmd_key_r);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = kvt_pkg::IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = kvt_pkg::IDX_W'(i);
      end
    end
    hit_any  = |match;
    free_any = !(&valid_r);
  end

  always_comb begin
    valid_nxt    = valid_r;
    cnt_nxt      = cnt_r;
    wr_key_en    = 1'b0;
    wr_data_en   = 1'b0;
    wr_idx       = hit_idx;
    res_hit_nxt  = 1'b0;
    res_data_nxt = '0;
    res_full_nxt = 1'b0;
    if (cmd_v_r) begin
      case (kvt_pkg::action_t'(cmd_act_r))
        kvt_pkg::ACT_ADD: begin
          if (hit_any) begin
            res_hit_nxt  = 1'b1;
            res_data_nxt = data_r[hit_idx];
            wr_data_en   = 1'b1;
          end else if (free_any) begin
            wr_idx              = free_idx;
            wr_key_en           = 1'b1;
            wr_data_en          = 1'b1;
            valid_nxt[free_idx] = 1'b1;
            cnt_nxt             = cnt_r + kvt_pkg::CNT_W'(1);
          end else begin
            res_full_nxt = 1'b1;
          end
        end
        kvt_pkg::ACT_SEARCH: begin
          if (hit_any) begin
            res_hit_nxt  = 1'b1;
            res_data_nxt = data_r[hit_idx];
          end
        end
        kvt_pkg::ACT_REMOVE: begin
          if (hit_any) begin
            res_hit_nxt        = 1'b1;
            res_data_nxt       = data_r[hit_idx];
            valid_nxt[hit_idx] = 1'b0;
            cnt_nxt            = cnt_r - kvt_pkg::CNT_W'(1);
          end
        end
        default: begin
          // unused code: no change
        end
      endcase
    end
    cnt_ext       = {{kvt_pkg::COUNT_W{1'b0}}, cnt_nxt};
    res_cnt_nxt   = cnt_ext[kvt_pkg::COUNT_W-1:0];
    res_empty_nxt = (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      res_v_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      res_v_r <= cmd_v_r;
    end
    if (wr_key_en) begin
      key_r[wr_idx] <= cmd_key_r;
    end
    if (wr_data_en) begin
      data_r[wr_idx] <= cmd_din_r;
    end
    res_hit_r   <= res_hit_nxt;
    res_data_r  <= res_data_nxt;
    res_full_r  <= res_full_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_empty_r <= res_empty_nxt;
  end

  assign out_valid     = res_v_r;
  assign out_hit       = res_hit_r;
  assign out_data_out  = res_data_r;
  assign out_full_res  = res_full_r;
  assign out_count     = res_cnt_r;
  assign out_empty_res = res_empty_r;

endmodule

`default_nettype wire

// ===== rtl/core/kvt_checker.sv =====
// Port-level checker for key_value_table, attached with bind.
// Depends on kvt_pkg for field widths and table size.
`timescale 1ns / 1ps
`default_nettype none

module kvt_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic                          out_hit,
  input wire logic [kvt_pkg::DATA_W-1:0]    out_data_out,
  input wire logic                          out_full_res,
  input wire logic [kvt_pkg::COUNT_W-1:0]   out_count,
  input wire logic                          out_empty_res
);

  // one result beat for each accepted command, after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == ($past(start && !busy && rst_n, 2) && $past(rst_n, 1)))
    else $error("result beat does not follow command by two cycles");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_res) |-> (!out_hit && out_data_out == '0))
    else $error("rejected add reports hit or data");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_data_out == '0))
    else $error("miss returned nonzero data");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= kvt_pkg::ENTRIES))
    else $error("count above table size");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_hit       (out_hit),
  .out_data_out  (out_data_out),
  .out_full_res  (out_full_res),
  .out_count     (out_count),
  .out_empty_res (out_empty_res)
);

`default_nettype wire
